### src/dbrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrs_pkg
// Shared widths, register indexes, reset values and event codes for the
// burn-wire deployment sequencer.
// ----------------------------------------------------------------------------
package dbrs_pkg;

    localparam int TICK_W    = 16;
    localparam int ATTEMPT_W = 3;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [TICK_W-1:0]    PULSE_TICKS_RST  = 16'd3000;
    localparam logic [TICK_W-1:0]    WAIT_TICKS_RST   = 16'd10000;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 3'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd2;

    // Event codes on event_res
    localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DONE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_FAIL = 2'd2;

    typedef struct packed {
        logic                 burn_on;
        logic [EVENT_W-1:0]   event_res;
        logic [ATTEMPT_W-1:0] attempt_number;
        logic                 busy_res;
    } result_t;

endpackage

### src/deploy_burn_retry_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deploy_burn_retry_sequencer_unit
// An accepted item's result is registered, into the skid register while one waits.
// Throughput: one item per cycle while in_stall is low; the state update is a single
// 16-bit increment and compare between the sequencer registers.
// A two-entry output (result register plus skid register) keeps input taking
// items while a result waits; in_stall rises only when both are full.
// Reset (rst_n, async low): phase idle, counters zero, registers to defaults.
// ----------------------------------------------------------------------------
module deploy_burn_retry_sequencer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [dbrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbrs_pkg::CFG_W-1:0]         cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               start_req,
    input  logic                               tick,
    input  logic                               deployed_sense,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               burn_on,
    output logic [dbrs_pkg::EVENT_W-1:0]       event_res,
    output logic [dbrs_pkg::ATTEMPT_W-1:0]     attempt_number,
    output logic                               busy_res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BURN = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    logic [dbrs_pkg::TICK_W-1:0]    pulse_ticks_reg;
    logic [dbrs_pkg::TICK_W-1:0]    wait_ticks_reg;
    logic [dbrs_pkg::ATTEMPT_W-1:0] max_attempts_reg;

    phase_t                         phase_reg, phase_next;
    logic [dbrs_pkg::TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic [dbrs_pkg::ATTEMPT_W-1:0] attempt_reg, attempt_next;

    dbrs_pkg::result_t              res_next;
    dbrs_pkg::result_t              out_reg;
    dbrs_pkg::result_t              skid_reg;
    logic                           out_valid_reg;
    logic                           skid_valid_reg;

    logic [dbrs_pkg::TICK_W-1:0]    tick_inc;
    logic [dbrs_pkg::EVENT_W-1:0]   ev;
    logic [dbrs_pkg::ATTEMPT_W-1:0] report;
    logic                           accept;
    logic                           out_take;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign tick_inc = tick_count_reg + 16'd1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg  <= dbrs_pkg::PULSE_TICKS_RST;
            wait_ticks_reg   <= dbrs_pkg::WAIT_TICKS_RST;
            max_attempts_reg <= dbrs_pkg::MAX_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbrs_pkg::REG_PULSE_TICKS:  pulse_ticks_reg  <= cfg_data;
                dbrs_pkg::REG_WAIT_TICKS:   wait_ticks_reg   <= cfg_data;
                dbrs_pkg::REG_MAX_ATTEMPTS:
                    max_attempts_reg <= cfg_data[dbrs_pkg::ATTEMPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        attempt_next    = attempt_reg;
        ev              = dbrs_pkg::EV_NONE;
        report          = '0;

        unique case (phase_reg)
            PH_BURN:
            begin
                if (tick)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= pulse_ticks_reg)
                    begin
                        tick_count_next = '0;
                        if (deployed_sense)
                        begin
                            ev           = dbrs_pkg::EV_DONE;
                            report       = attempt_reg;
                            phase_next   = PH_IDLE;
                            attempt_next = '0;
                        end
                        else if (attempt_reg >= max_attempts_reg)
                        begin
                            ev           = dbrs_pkg::EV_FAIL;
                            report       = attempt_reg;
                            phase_next   = PH_IDLE;
                            attempt_next = '0;
                        end
                        else if (wait_ticks_reg == '0)
                        begin
                            // no cool-down: burn again at once
                            attempt_next = attempt_reg + 3'd1;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
            end
            PH_WAIT:
            begin
                if (tick)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= wait_ticks_reg)
                    begin
                        tick_count_next = '0;
                        attempt_next    = attempt_reg + 3'd1;
                        phase_next      = PH_BURN;
                    end
                end
            end
            default:
            begin
                // idle, and the unused code acts as idle
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    phase_next      = PH_BURN;
                    tick_count_next = '0;
                    attempt_next    = 3'd1;
                end
            end
        endcase

        res_next.burn_on   = (phase_next == PH_BURN);
        res_next.event_res = ev;
        res_next.busy_res  = (phase_next != PH_IDLE);
        if (ev != dbrs_pkg::EV_NONE)
            res_next.attempt_number = report;
        else
            res_next.attempt_number = (phase_next == PH_IDLE) ? '0 : attempt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            attempt_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            attempt_reg    <= attempt_next;
        end
    end

    // Output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!out_valid_reg || out_take)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                // advance the skid item, or drop valid
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
        else if (out_take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign in_stall       = skid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign burn_on        = out_reg.burn_on;
    assign event_res      = out_reg.event_res;
    assign attempt_number = out_reg.attempt_number;
    assign busy_res       = out_reg.busy_res;

endmodule

### src/dbrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrs_checker
// Port-level checks on the sequencer results, bound to the top level.
// ----------------------------------------------------------------------------
module dbrs_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               burn_on,
    input logic [dbrs_pkg::EVENT_W-1:0]       event_res,
    input logic [dbrs_pkg::ATTEMPT_W-1:0]     attempt_number,
    input logic                               busy_res
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A finished sequence leaves the block idle
    a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != dbrs_pkg::EV_NONE |-> !busy_res && !burn_on)
        else $error("event reported while busy");

    // Burning always has an attempt under way
    a_burn_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && burn_on |-> busy_res && attempt_number != '0)
        else $error("burn without a running attempt");

    // Quiet idle results carry no attempt number
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res && event_res == dbrs_pkg::EV_NONE
            |-> attempt_number == '0)
        else $error("attempt number while idle");

    // Only defined event codes appear on a valid result
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res == dbrs_pkg::EV_NONE || event_res == dbrs_pkg::EV_DONE
            || event_res == dbrs_pkg::EV_FAIL)
        else $error("undefined event code");

endmodule

bind deploy_burn_retry_sequencer_unit dbrs_checker u_dbrs_checker (.*);

### tb/deploy_burn_retry_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deploy_burn_retry_sequencer_unit_tb
// Drives tick, start and switch items into the burn-wire sequencer through
// random sender gaps and receiver stalls. An item-by-item copy of the sequencer
// tracks phase, tick count and attempt number, and every reported item is
// compared field by field against it.
// ----------------------------------------------------------------------------
module deploy_burn_retry_sequencer_unit_tb;

    localparam int IDLE_PCT    = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SHOWN_ERRS  = 10;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_BURN, SEQ_COOL} seq_phase_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [dbrs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dbrs_pkg::CFG_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           start_req;
    logic                           tick;
    logic                           deployed_sense;
    logic                           out_valid;
    logic                           out_stall;
    logic                           burn_on;
    logic [dbrs_pkg::EVENT_W-1:0]   event_res;
    logic [dbrs_pkg::ATTEMPT_W-1:0] attempt_number;
    logic                           busy_res;

    // Shadow copy of the sequencer and its registers
    seq_phase_t                     seq_phase;
    logic [dbrs_pkg::TICK_W-1:0]    seq_ticks;
    logic [dbrs_pkg::ATTEMPT_W-1:0] seq_attempt;
    logic [dbrs_pkg::TICK_W-1:0]    burn_len;
    logic [dbrs_pkg::TICK_W-1:0]    cool_len;
    logic [dbrs_pkg::ATTEMPT_W-1:0] attempt_limit;

    dbrs_pkg::result_t pending_reports[$];

    int  errors;
    int  items_sent;
    int  confirmed;
    int  failed;
    int  deepest_attempt;
    int  input_stall_cycles;
    int  quiet_cycles;
    bit  no_idle;
    bit  hold_request;
    int  hold_left;

    deploy_burn_retry_sequencer_unit DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic dbrs_pkg::result_t sequence_next(input logic s, input logic t,
                                                        input logic d);
        dbrs_pkg::result_t              r;
        logic [dbrs_pkg::EVENT_W-1:0]   ev;
        logic [dbrs_pkg::ATTEMPT_W-1:0] rep;
        ev  = dbrs_pkg::EV_NONE;
        rep = '0;
        case (seq_phase)
            SEQ_BURN:
            begin
                if (t)
                begin
                    seq_ticks = seq_ticks + 1'b1;
                    if (seq_ticks >= burn_len)
                    begin
                        seq_ticks = '0;
                        if (d)
                        begin
                            ev          = dbrs_pkg::EV_DONE;
                            rep         = seq_attempt;
                            seq_phase   = SEQ_IDLE;
                            seq_attempt = '0;
                        end
                        else if (seq_attempt >= attempt_limit)
                        begin
                            ev          = dbrs_pkg::EV_FAIL;
                            rep         = seq_attempt;
                            seq_phase   = SEQ_IDLE;
                            seq_attempt = '0;
                        end
                        else if (cool_len == '0)
                        begin
                            // no cool-down: next attempt burns straight on
                            seq_attempt = seq_attempt + 1'b1;
                        end
                        else
                        begin
                            seq_phase = SEQ_COOL;
                        end
                    end
                end
            end
            SEQ_COOL:
            begin
                if (t)
                begin
                    seq_ticks = seq_ticks + 1'b1;
                    if (seq_ticks >= cool_len)
                    begin
                        seq_ticks   = '0;
                        seq_attempt = seq_attempt + 1'b1;
                        seq_phase   = SEQ_BURN;
                    end
                end
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
                if (s)
                begin
                    seq_phase   = SEQ_BURN;
                    seq_ticks   = '0;
                    seq_attempt = 3'd1;
                end
            end
        endcase
        if (ev == dbrs_pkg::EV_NONE)
            rep = (seq_phase == SEQ_IDLE) ? '0 : seq_attempt;
        r.burn_on        = (seq_phase == SEQ_BURN);
        r.event_res      = ev;
        r.attempt_number = rep;
        r.busy_res       = (seq_phase != SEQ_IDLE);
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input dbrs_pkg::result_t exp_r,
                                          input dbrs_pkg::result_t act_r);
        if (errors < SHOWN_ERRS)
            $display("[%0t] %s: expected burn=%0b ev=%0d att=%0d busy=%0b, %s",
                     $realtime, what, exp_r.burn_on, exp_r.event_res,
                     exp_r.attempt_number, exp_r.busy_res,
                     $sformatf("got burn=%0b ev=%0d att=%0d busy=%0b",
                               act_r.burn_on, act_r.event_res, act_r.attempt_number,
                               act_r.busy_res));
        errors++;
    endfunction

    // Offer one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(input logic s, input logic t, input logic d);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        start_req      <= s;
        tick           <= t;
        deployed_sense <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_reports.push_back(sequence_next(s, t, d));
        items_sent++;
    endtask

    // Drop valid and let every outstanding report drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dbrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbrs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dbrs_pkg::REG_PULSE_TICKS:  burn_len      = val;
            dbrs_pkg::REG_WAIT_TICKS:   cool_len      = val;
            dbrs_pkg::REG_MAX_ATTEMPTS: attempt_limit = val[dbrs_pkg::ATTEMPT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [dbrs_pkg::CFG_W-1:0] pulse,
                              input logic [dbrs_pkg::CFG_W-1:0] cool,
                              input logic [dbrs_pkg::CFG_W-1:0] tries);
        settle();
        write_reg(dbrs_pkg::REG_PULSE_TICKS, pulse);
        write_reg(dbrs_pkg::REG_WAIT_TICKS, cool);
        write_reg(dbrs_pkg::REG_MAX_ATTEMPTS, tries);
    endtask

    // Defaults after reset: idle ticks, start with tick, start while busy
    task automatic test_reset_defaults();
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b1, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_special_cases();
        // zero pulse, zero cool-down and zero attempt limit, hit mid-burn
        set_timing('0, '0, '0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        // back-to-back retries up to seven attempts, then failure
        set_timing(16'd1, '0, 16'd7);
        send_item(1'b1, 1'b0, 1'b0);
        repeat (7) send_item(1'b0, 1'b1, 1'b0);
        // cool-down between attempts, confirmed on the second
        set_timing(16'd1, 16'd2, 16'd2);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
    endtask

    // Full-scale counters, then shorten them while a sequence is in flight
    task automatic test_full_scale();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 1'b1, 1'b1);
        repeat (3) send_item(1'b0, 1'b1, 1'b1);
        set_timing(16'd2, 16'hFFFF, 16'd7);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        set_timing(16'd2, 16'd1, 16'd7);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b1, 1'b1);
    endtask

    // Receiver holds off long enough for both output slots to fill
    task automatic test_output_hold();
        set_timing(16'd2, 16'd1, 16'd3);
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (40)
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [dbrs_pkg::CFG_W-1:0] pulse;
        logic [dbrs_pkg::CFG_W-1:0] cool;
        logic [dbrs_pkg::CFG_W-1:0] tries;
        int                         sense_pct;
        logic                       s;
        logic                       t;
        logic                       d;
        for (int k = 0; k < 6; k++)
        begin
            pulse = 16'($urandom_range(0, 6));
            cool  = 16'($urandom_range(0, 6));
            tries = 16'($urandom_range(0, 7));
            if (k == 0)
            begin
                cool  = '0;
                tries = 16'd7;
            end
            else if (k == 1)
            begin
                pulse = '0;
                tries = '0;
            end
            // junk above the attempt field must be dropped
            tries     = {13'($urandom_range(0, 8191)), tries[dbrs_pkg::ATTEMPT_W-1:0]};
            sense_pct = $urandom_range(8, 45);
            set_timing(pulse, cool, tries);
            no_idle = (k == 2);
            repeat (90)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    s = 1'($urandom_range(0, 1));
                    t = 1'($urandom_range(0, 1));
                    d = 1'($urandom_range(0, 1));
                end
                else
                begin
                    s = (seq_phase == SEQ_IDLE) ? ($urandom_range(0, 99) < 60)
                                                : ($urandom_range(0, 99) < 10);
                    t = ($urandom_range(0, 99) < 75);
                    d = ($urandom_range(0, 99) < sense_pct);
                end
                send_item(s, t, d);
            end
            no_idle = 1'b0;
        end
    endtask

    // Receiver: random stalls, plus a counted hold when one is requested
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare each report with the oldest prediction
    always @(posedge clk)
    begin
        dbrs_pkg::result_t got;
        dbrs_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {burn_on, event_res, attempt_number, busy_res};
            if (pending_reports.size() == 0)
                note_mismatch("unexpected report", '0, got);
            else
            begin
                want = pending_reports.pop_front();
                if (got.burn_on !== want.burn_on || got.event_res !== want.event_res ||
                    got.attempt_number !== want.attempt_number ||
                    got.busy_res !== want.busy_res)
                    note_mismatch("report mismatch", want, got);
                if (got.event_res == dbrs_pkg::EV_DONE)
                    confirmed++;
                if (got.event_res == dbrs_pkg::EV_FAIL)
                    failed++;
                if (got.event_res != dbrs_pkg::EV_NONE &&
                    int'(got.attempt_number) > deepest_attempt)
                    deepest_attempt = int'(got.attempt_number);
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_stall_cycles++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        start_req          = 1'b0;
        tick               = 1'b0;
        deployed_sense     = 1'b0;
        no_idle            = 1'b0;
        hold_request       = 1'b0;
        errors             = 0;
        items_sent         = 0;
        confirmed          = 0;
        failed             = 0;
        deepest_attempt    = 0;
        input_stall_cycles = 0;
        quiet_cycles       = 0;
        seq_phase          = SEQ_IDLE;
        seq_ticks          = '0;
        seq_attempt        = '0;
        burn_len           = dbrs_pkg::PULSE_TICKS_RST;
        cool_len           = dbrs_pkg::WAIT_TICKS_RST;
        attempt_limit      = dbrs_pkg::MAX_ATTEMPTS_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_full_scale();
        test_output_hold();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $display("%0d predicted reports never arrived", pending_reports.size());
            errors += pending_reports.size();
        end

        $display("Ran %0d items over zero, full-scale and random timings: %0d confirmed, %s",
                 items_sent, confirmed, $sformatf("%0d failed", failed));
        $display("Deepest reported attempt %0d, input held off for %0d cycles, %s",
                 deepest_attempt, input_stall_cycles, $sformatf("%0d mismatches", errors));
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
